// ===== hdl/lmp_pkg.sv =====
// ----------------------------------------------------------------------------
// lmp_pkg
// Shared types and constants of the lamp matrix persistence store.
// ----------------------------------------------------------------------------
package lmp_pkg;

  localparam int unsigned LAMP_COUNT_DEF = 512;
  localparam int unsigned IDX_MAX_W      = 12;
  localparam int unsigned BASE_W         = 10;
  localparam int unsigned SCAN_W         = 10;
  localparam int unsigned PERSIST_W      = 8;
  localparam int unsigned LEVEL_W        = 8;
  localparam int unsigned COUNT_W        = 10;
  localparam int unsigned CFG_DATA_W     = 10;
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned COLUMN_LAMPS   = 8;
  localparam int unsigned GROUP_LAMPS    = 16;
  localparam int unsigned STATIC_LAMPS   = 8;

  localparam logic [LEVEL_W-1:0]   LEVEL_PERMANENT = 8'd255;
  localparam logic [PERSIST_W-1:0] PERSIST_RESET   = 8'd10;
  localparam logic [SCAN_W-1:0]    SCAN_RESET      = 10'd320;

  typedef enum logic [1:0] {
    FUNC_COLUMN = 2'd0,
    FUNC_DECAY  = 2'd1,
    FUNC_GROUP  = 2'd2,
    FUNC_STATIC = 2'd3
  } func_e;

  typedef enum logic {
    REG_PERSISTENCE = 1'b0,
    REG_SCAN_COUNT  = 1'b1
  } reg_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] data;
    logic [4:0]  column;
    logic [7:0]  bank;
    logic [8:0]  address;
  } in_item_t;

  typedef struct packed {
    logic               changed;
    logic [COUNT_W-1:0] lamps_on;
    logic [LEVEL_W-1:0] level;
  } out_item_t;

  typedef struct packed {
    func_e                func;
    logic [15:0]          pattern;
    logic [IDX_MAX_W-1:0] base;
    logic [IDX_MAX_W-1:0] rpt;
  } cmd_t;

endpackage

// ===== hdl/lmp_front.sv =====
// ----------------------------------------------------------------------------
// lmp_front
// Accepts input transactions, forms the base lamp and report lamp of each
// and wraps them into the store's range before queuing the command.
// ----------------------------------------------------------------------------
module lmp_front
  import lmp_pkg::*;
#(
  parameter int unsigned LAMP_COUNT = LAMP_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     clr_done_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     fifo_full_i,
  output logic     fifo_push_o,
  output cmd_t     fifo_cmd_o
);

  localparam int unsigned IW = $clog2(LAMP_COUNT);
  localparam int unsigned RW = (IW + 1 > BASE_W) ? IW + 1 : BASE_W;
  localparam logic [RW-1:0] LIMIT = RW'(LAMP_COUNT);

  typedef enum logic {
    F_IDLE,
    F_REDUCE
  } f_state_e;

  f_state_e    state_q, state_d;
  logic [RW-1:0] base_q, base_d;
  logic [RW-1:0] rpt_q, rpt_d;
  func_e       func_q, func_d;
  logic [15:0] data_q, data_d;
  logic        base_hi, rpt_hi, accept;
  logic [RW-1:0] base_raw;

  assign in_ready_o = (state_q == F_IDLE) && clr_done_i;
  assign accept     = in_valid_i && in_ready_o;
  assign base_hi    = base_q >= LIMIT;
  assign rpt_hi     = rpt_q >= LIMIT;

  always_comb begin
    unique case (in_item_i.func)
      FUNC_COLUMN: base_raw = RW'({2'b00, in_item_i.bank})
                            + RW'({in_item_i.column, 3'b000});
      FUNC_GROUP:  base_raw = RW'({in_item_i.column, 4'b0000});
      FUNC_STATIC: base_raw = RW'(in_item_i.address);
      default:     base_raw = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    rpt_d       = rpt_q;
    func_d      = func_q;
    data_d      = data_q;
    fifo_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          base_d  = base_raw;
          rpt_d   = RW'(in_item_i.address);
          func_d  = in_item_i.func;
          data_d  = in_item_i.data;
          state_d = F_REDUCE;
        end
      end
      F_REDUCE: begin
        if (base_hi) begin
          base_d = base_q - LIMIT;
        end
        if (rpt_hi) begin
          rpt_d = rpt_q - LIMIT;
        end
        if (!base_hi && !rpt_hi && !fifo_full_i) begin
          fifo_push_o = 1'b1;
          state_d     = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    fifo_cmd_o.func    = func_q;
    fifo_cmd_o.pattern = data_q;
    fifo_cmd_o.base    = IDX_MAX_W'(base_q[IW-1:0]);
    fifo_cmd_o.rpt     = IDX_MAX_W'(rpt_q[IW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rpt_q  <= rpt_d;
    func_q <= func_d;
    data_q <= data_d;
  end

endmodule

// ===== hdl/lmp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lmp_cmd_fifo
// Short command queue between the front and the back of the store.
// ----------------------------------------------------------------------------
module lmp_cmd_fifo
  import lmp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          slot_q [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] fill_q;
  logic          do_push, do_pop;

  assign full_o  = fill_q == NW'(CMD_FIFO_DEPTH);
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/lmp_back.sv =====
// ----------------------------------------------------------------------------
// lmp_back
// Level memory and lamp sequencer: clears the store after reset, walks the
// lamps of each command one per cycle, keeps the lit count and returns the
// result transaction.
// ----------------------------------------------------------------------------
module lmp_back
  import lmp_pkg::*;
#(
  parameter int unsigned LAMP_COUNT = LAMP_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PERSIST_W-1:0] persistence_i,
  input  logic [SCAN_W-1:0]    scan_count_i,
  output logic                 clr_done_o,
  input  logic                 fifo_empty_i,
  input  cmd_t                 fifo_cmd_i,
  output logic                 fifo_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  localparam int unsigned IW = $clog2(LAMP_COUNT);
  localparam int unsigned LW = $clog2(LAMP_COUNT + 1);
  localparam int unsigned CW = (IW + 1 > SCAN_W) ? IW + 1 : SCAN_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(LAMP_COUNT - 1);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RUN,
    B_RPT,
    B_RESP
  } b_state_e;

  b_state_e     state_q;
  cmd_t         cmd_q;
  logic [IW-1:0] clr_idx_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] wr_idx_q;
  logic [3:0]   pos_q;
  logic [CW-1:0] left_q;
  logic         rd_vld_q;
  logic         rd_bit_q;
  logic         chg_q;
  logic [LW-1:0] lit_q;
  logic         out_valid_q;
  out_item_t    out_q;

  logic [LEVEL_W-1:0] mem [LAMP_COUNT];
  logic [LEVEL_W-1:0] rd_data_q;
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_wa, mem_ra;
  logic [LEVEL_W-1:0] mem_wd;

  logic               lamp_we, was_on, now_on;
  logic [LEVEL_W-1:0] lamp_new;
  logic [CW-1:0]      scan_n, start_left;

  assign clr_done_o  = state_q != B_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign fifo_pop_o  = (state_q == B_IDLE) && !fifo_empty_i;

  assign scan_n = (CW'(scan_count_i) > CW'(LAMP_COUNT)) ? CW'(LAMP_COUNT)
                                                        : CW'(scan_count_i);

  always_comb begin
    unique case (fifo_cmd_i.func)
      FUNC_COLUMN: start_left = CW'(COLUMN_LAMPS);
      FUNC_GROUP:  start_left = CW'(GROUP_LAMPS);
      FUNC_STATIC: start_left = CW'(STATIC_LAMPS);
      default:     start_left = scan_n;
    endcase
  end

  // Per-lamp update of the level read in the previous cycle
  always_comb begin
    lamp_we  = 1'b0;
    lamp_new = persistence_i;
    unique case (cmd_q.func)
      FUNC_COLUMN, FUNC_GROUP: begin
        lamp_we  = rd_bit_q;
        lamp_new = persistence_i;
      end
      FUNC_STATIC: begin
        if (rd_bit_q) begin
          lamp_we  = rd_data_q == '0;
          lamp_new = LEVEL_PERMANENT;
        end else begin
          lamp_we  = rd_data_q == LEVEL_PERMANENT;
          lamp_new = '0;
        end
      end
      default: begin
        lamp_we  = (rd_data_q != '0) && (rd_data_q != LEVEL_PERMANENT);
        lamp_new = rd_data_q - 1'b1;
      end
    endcase
  end

  assign was_on = rd_data_q != '0;
  assign now_on = lamp_new != '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_idx_q;
    mem_wd = lamp_new;
    mem_re = 1'b0;
    mem_ra = idx_q;
    unique case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_q;
        mem_wd = '0;
      end
      B_RUN: begin
        mem_we = rd_vld_q && lamp_we;
        mem_re = left_q != '0;
      end
      B_RPT: begin
        mem_re = !out_valid_q;
        mem_ra = cmd_q.rpt[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_idx_q   <= '0;
      lit_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == IDX_LAST) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!fifo_empty_i) begin
            cmd_q    <= fifo_cmd_i;
            idx_q    <= fifo_cmd_i.base[IW-1:0];
            pos_q    <= '0;
            left_q   <= start_left;
            rd_vld_q <= 1'b0;
            chg_q    <= 1'b0;
            state_q  <= B_RUN;
          end
        end
        B_RUN: begin
          if (rd_vld_q && lamp_we && (was_on != now_on)) begin
            chg_q <= 1'b1;
            if (now_on) begin
              lit_q <= lit_q + 1'b1;
            end else begin
              lit_q <= lit_q - 1'b1;
            end
          end
          if (left_q != '0) begin
            rd_vld_q <= 1'b1;
            rd_bit_q <= cmd_q.pattern[pos_q];
            wr_idx_q <= idx_q;
            idx_q    <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
            pos_q    <= pos_q + 1'b1;
            left_q   <= left_q - 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
            state_q  <= B_RPT;
          end
        end
        B_RPT: begin
          if (!out_valid_q) begin
            state_q <= B_RESP;
          end
        end
        B_RESP: begin
          out_valid_q    <= 1'b1;
          out_q.changed  <= chg_q;
          out_q.lamps_on <= COUNT_W'(lit_q);
          out_q.level    <= rd_data_q;
          state_q        <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lamp_matrix_persistence.sv =====
// ----------------------------------------------------------------------------
// lamp_matrix_persistence
// Hold-level store for the lamps of a multiplexed lamp matrix.
//
// Input channel (in_valid_i / in_ready_o, in_item_i): one transaction per
// operation: column write, group write, static write or decay tick.
// Output channel (out_valid_o / out_ready_i, out_item_o): one transaction
// per input: change flag, lit lamp count and level of the addressed lamp.
// Configuration: cfg_we_i writes cfg_data_i into the register at
// cfg_index_i (persistence, scan count) at once; write only while idle.
// Lamps walked per transaction: 8 for column and static writes, 16 for
// group writes and min(scan_count, LAMP_COUNT) for a decay tick. The level
// memory has a single read port, walked one lamp per cycle. Further
// transactions queue in the front and the command queue while one runs. A
// base or reported lamp beyond the store is wrapped into range by the front
// before the command is queued (no wrap occurs with 512 lamps).
// Reset: a clearing pass zeroes the memory; in_ready_o stays low until it
// ends. A stalled receiver holds the result in the output register; a
// further command still runs up to its report read.
// ----------------------------------------------------------------------------
module lamp_matrix_persistence
  import lmp_pkg::*;
#(
  parameter int unsigned LAMP_COUNT = LAMP_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  reg_e                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [PERSIST_W-1:0] persistence_q;
  logic [SCAN_W-1:0]    scan_count_q;
  logic                 clr_done;
  logic                 fifo_push, fifo_full;
  logic                 fifo_pop, fifo_empty;
  cmd_t                 push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persistence_q <= PERSIST_RESET;
      scan_count_q  <= SCAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PERSISTENCE: persistence_q <= cfg_data_i[PERSIST_W-1:0];
        REG_SCAN_COUNT:  scan_count_q  <= cfg_data_i[SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  lmp_front #(
    .LAMP_COUNT(LAMP_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_done_i (clr_done),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .fifo_full_i(fifo_full),
    .fifo_push_o(fifo_push),
    .fifo_cmd_o (push_cmd)
  );

  lmp_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .cmd_i  (push_cmd),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .cmd_o  (pop_cmd),
    .empty_o(fifo_empty)
  );

  lmp_back #(
    .LAMP_COUNT(LAMP_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .persistence_i(persistence_q),
    .scan_count_i (scan_count_q),
    .clr_done_o   (clr_done),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (pop_cmd),
    .fifo_pop_o   (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
